>>> rtl/hwlc_pkg.sv
`timescale 1ns / 1ps

package hwlc_pkg;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_EVAL  = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    // Fixed field widths of the channels and of the register.
    localparam int TBIN_W   = 4;
    localparam int LAYER_W  = 3;
    localparam int HSTRIP_W = 6;
    localparam int BITS_W   = 64;
    localparam int CNT_W    = 3;
    localparam int MASK_W   = 6;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] PERSIST_RESET = 5'd4;

endpackage

>>> rtl/hwlc_if.sv
`timescale 1ns / 1ps

interface hwlc_in_if;
    import hwlc_pkg::*;

    logic                valid;
    logic                ready;
    t_req                req_type;
    logic [TBIN_W-1:0]   time_bin;
    logic [LAYER_W-1:0]  layer_number;
    logic [HSTRIP_W-1:0] half_strip;

    modport source (
        output valid, req_type, time_bin, layer_number, half_strip,
        input  ready
    );
    modport sink (
        input  valid, req_type, time_bin, layer_number, half_strip,
        output ready
    );
endinterface

interface hwlc_out_if;
    import hwlc_pkg::*;

    logic               valid;
    logic               ready;
    logic [LAYER_W-1:0] layer_index;
    logic [BITS_W-1:0]  strip_bits;
    logic [CNT_W-1:0]   layers_hit;
    logic [TBIN_W-1:0]  window_start;
    logic [MASK_W-1:0]  layer_mask;
    logic               last;

    modport source (
        output valid, layer_index, strip_bits, layers_hit, window_start, layer_mask, last,
        input  ready
    );
    modport sink (
        input  valid, layer_index, strip_bits, layers_hit, window_start, layer_mask, last,
        output ready
    );
endinterface

>>> rtl/hit_window_layer_count.sv
`timescale 1ns / 1ps

// Channel    Dir  Payload                                            Beat
// i_in       in   req_type, time_bin, layer_number, half_strip       valid & ready
// o_res      out  layer_index, strip_bits, layers_hit, window_start,  valid & ready
//                 layer_mask, last
// i_cfg_*    in   persist_window (5 bits)                            i_cfg_we
//
// A clear completes on acceptance, and a load goes through read, merge and write.
// A query reads each layer in turn and then gives its result beat. An evaluate
// accepts the request, tries one window per cycle (at most NUM_TIME_BINS - len + 1),
// then ORs the chosen window out of the single memory read port one bin at a time
// for each layer, with one result beat per layer.
// Reset is synchronous and active low; it empties the hit map at once through
// per-word valid bits and loads persist_window with 4.
// The block takes no input beat while a request is in flight, and holds a
// result beat until the sink accepts it.
module hit_window_layer_count #(
    parameter int NUM_HALF_STRIPS = 64,
    parameter int NUM_TIME_BINS   = 16,
    parameter int NUM_LAYERS      = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hwlc_in_if.sink                    i_in,
    hwlc_out_if.source                 o_res,
    input  logic                       i_cfg_we,
    input  logic [hwlc_pkg::CFG_W-1:0] i_cfg_wdata
);
    import hwlc_pkg::*;

    localparam int DEPTH = NUM_TIME_BINS * NUM_LAYERS;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = $clog2(NUM_HALF_STRIPS);
    localparam int CW    = $clog2(NUM_LAYERS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_ACC,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    t_req                   r_op, n_op;
    logic [CFG_W-1:0]       r_persist;
    logic [CFG_W-1:0]       r_len, n_len;
    logic [TBIN_W-1:0]      r_start, n_start;
    logic [TBIN_W-1:0]      r_best_start, n_best_start;
    logic [CW-1:0]          r_best_cnt, n_best_cnt;
    logic                   r_have, n_have;
    logic [TBIN_W-1:0]      r_bin, n_bin;
    logic [LAYER_W-1:0]     r_lay, n_lay;
    logic [HSTRIP_W-1:0]    r_hs, n_hs;
    logic [NUM_HALF_STRIPS-1:0] r_acc, n_acc;
    logic [NUM_LAYERS-1:0]  r_mask, n_mask;

    logic                   r_out_valid, n_out_valid;
    logic [LAYER_W-1:0]     r_o_layer, n_o_layer;
    logic [BITS_W-1:0]      r_o_bits, n_o_bits;
    logic [CNT_W-1:0]       r_o_cnt, n_o_cnt;
    logic [TBIN_W-1:0]      r_o_start, n_o_start;
    logic [MASK_W-1:0]      r_o_mask, n_o_mask;
    logic                   r_o_last, n_o_last;

    logic                       w_in_acc;
    logic                       w_out_acc;
    logic                       w_clr;
    logic                       w_we;
    logic [AW-1:0]              w_addr;
    logic [NUM_HALF_STRIPS-1:0] w_rdata;
    logic [NUM_HALF_STRIPS-1:0] w_wdata;
    logic [DEPTH-1:0]           w_valid;
    logic [CW-1:0]              w_cnt;
    logic                       w_load_ok;
    logic                       w_query_ok;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = r_out_valid && o_res.ready;
    assign w_clr     = w_in_acc && (i_in.req_type == REQ_CLEAR);

    // One address serves both the read issue and the merge write of a load,
    // since the counters do not move between the read and the write.
    assign w_addr  = AW'(32'(r_bin) * NUM_LAYERS + 32'(r_lay));
    assign w_we    = (r_state == S_ACC) && (r_op == REQ_LOAD);
    assign w_wdata = w_rdata | (NUM_HALF_STRIPS'(1) << r_hs[HW-1:0]);

    assign w_load_ok = (32'(i_in.layer_number) >= 1)
                    && (32'(i_in.layer_number) <= NUM_LAYERS)
                    && (32'(i_in.time_bin) < NUM_TIME_BINS)
                    && (32'(i_in.half_strip) < NUM_HALF_STRIPS);
    assign w_query_ok = (32'(i_in.time_bin) < NUM_TIME_BINS)
                     && (32'(i_in.half_strip) < NUM_HALF_STRIPS);

    hwlc_store #(
        .DEPTH (DEPTH),
        .WIDTH (NUM_HALF_STRIPS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_clr),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata),
        .o_valid (w_valid)
    );

    hwlc_win_count #(
        .NUM_TIME_BINS (NUM_TIME_BINS),
        .NUM_LAYERS    (NUM_LAYERS)
    ) u_win (
        .i_valid (w_valid),
        .i_start (r_start),
        .i_len   (r_len),
        .o_count (w_cnt)
    );

    // Configuration register: written whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persist <= PERSIST_RESET;
        end else if (i_cfg_we) begin
            r_persist <= i_cfg_wdata;
        end
    end

    always_comb begin
        logic w_full;
        logic w_take;
        logic w_last_win;
        n_state      = r_state;
        n_op         = r_op;
        n_len        = r_len;
        n_start      = r_start;
        n_best_start = r_best_start;
        n_best_cnt   = r_best_cnt;
        n_have       = r_have;
        n_bin        = r_bin;
        n_lay        = r_lay;
        n_hs         = r_hs;
        n_acc        = r_acc;
        n_mask       = r_mask;
        n_out_valid  = r_out_valid;
        n_o_layer    = r_o_layer;
        n_o_bits     = r_o_bits;
        n_o_cnt      = r_o_cnt;
        n_o_start    = r_o_start;
        n_o_mask     = r_o_mask;
        n_o_last     = r_o_last;

        w_full     = (w_cnt == CW'(NUM_LAYERS));
        w_take     = !r_have || w_full || (w_cnt > r_best_cnt);
        w_last_win = ((CFG_W'(r_start) + r_len) == CFG_W'(NUM_TIME_BINS));

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op   = i_in.req_type;
                    n_bin  = i_in.time_bin;
                    n_hs   = i_in.half_strip;
                    n_lay  = '0;
                    n_mask = '0;
                    n_acc  = '0;
                    case (i_in.req_type)
                        REQ_CLEAR: begin
                            n_state = S_IDLE;
                        end
                        REQ_LOAD: begin
                            n_lay   = i_in.layer_number - LAYER_W'(1);
                            n_state = w_load_ok ? S_RD : S_IDLE;
                        end
                        REQ_EVAL: begin
                            // Saturate the window length into 1..NUM_TIME_BINS.
                            if (r_persist == '0) begin
                                n_len = CFG_W'(1);
                            end else if (32'(r_persist) > NUM_TIME_BINS) begin
                                n_len = CFG_W'(NUM_TIME_BINS);
                            end else begin
                                n_len = r_persist;
                            end
                            n_start = '0;
                            n_have  = 1'b0;
                            n_state = S_SCAN;
                        end
                        REQ_QUERY: begin
                            if (w_query_ok) begin
                                n_state = S_RD;
                            end else begin
                                n_out_valid = 1'b1;
                                n_o_layer   = '0;
                                n_o_bits    = '0;
                                n_o_cnt     = '0;
                                n_o_start   = '0;
                                n_o_mask    = '0;
                                n_o_last    = 1'b1;
                                n_state     = S_EMIT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // One window per cycle; the first full window ends the sweep.
                if (w_take) begin
                    n_best_start = r_start;
                    n_best_cnt   = w_cnt;
                    n_have       = 1'b1;
                end
                if (w_full || w_last_win) begin
                    n_lay   = '0;
                    n_bin   = w_take ? r_start : r_best_start;
                    n_acc   = '0;
                    n_state = S_RD;
                end else begin
                    n_start = r_start + TBIN_W'(1);
                end
            end

            S_RD: begin
                n_state = S_ACC;
            end

            S_ACC: begin
                case (r_op)
                    REQ_LOAD: begin
                        n_state = S_IDLE;
                    end
                    REQ_QUERY: begin
                        n_mask = r_mask
                               | (NUM_LAYERS'(w_rdata[r_hs[HW-1:0]]) << r_lay);
                        if (32'(r_lay) == NUM_LAYERS - 1) begin
                            n_out_valid = 1'b1;
                            n_o_layer   = '0;
                            n_o_bits    = '0;
                            n_o_cnt     = '0;
                            n_o_start   = '0;
                            n_o_mask    = MASK_W'(n_mask);
                            n_o_last    = 1'b1;
                            n_state     = S_EMIT;
                        end else begin
                            n_lay   = r_lay + LAYER_W'(1);
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_acc = r_acc | w_rdata;
                        if ((CFG_W'(r_bin) + CFG_W'(1)) == (CFG_W'(r_best_start) + r_len)) begin
                            n_out_valid = 1'b1;
                            n_o_layer   = r_lay;
                            n_o_bits    = BITS_W'(n_acc);
                            n_o_cnt     = CNT_W'(r_best_cnt);
                            n_o_start   = r_best_start;
                            n_o_mask    = '0;
                            n_o_last    = (32'(r_lay) == NUM_LAYERS - 1);
                            n_state     = S_EMIT;
                        end else begin
                            n_bin   = r_bin + TBIN_W'(1);
                            n_state = S_RD;
                        end
                    end
                endcase
            end

            S_EMIT: begin
                if (w_out_acc) begin
                    n_out_valid = 1'b0;
                    if ((r_op == REQ_EVAL) && (32'(r_lay) != NUM_LAYERS - 1)) begin
                        n_lay   = r_lay + LAYER_W'(1);
                        n_bin   = r_best_start;
                        n_acc   = '0;
                        n_state = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= REQ_CLEAR;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
        r_len        <= n_len;
        r_start      <= n_start;
        r_best_start <= n_best_start;
        r_best_cnt   <= n_best_cnt;
        r_bin        <= n_bin;
        r_lay        <= n_lay;
        r_hs         <= n_hs;
        r_acc        <= n_acc;
        r_mask       <= n_mask;
        r_o_layer    <= n_o_layer;
        r_o_bits     <= n_o_bits;
        r_o_cnt      <= n_o_cnt;
        r_o_start    <= n_o_start;
        r_o_mask     <= n_o_mask;
        r_o_last     <= n_o_last;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.layer_index  = r_o_layer;
    assign o_res.strip_bits   = r_o_bits;
    assign o_res.layers_hit   = r_o_cnt;
    assign o_res.window_start = r_o_start;
    assign o_res.layer_mask   = r_o_mask;
    assign o_res.last         = r_o_last;

endmodule

>>> rtl/hwlc_store.sv
`timescale 1ns / 1ps

// Hit map memory: one write port, one registered read port. A valid bit per
// word marks words written since the last clear; an unwritten word reads zero.
module hwlc_store #(
    parameter int DEPTH = 96,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    output logic [DEPTH-1:0]         o_valid
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_vld;
    logic [DEPTH-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;
    assign o_valid = r_vld;

endmodule

>>> rtl/hwlc_win_count.sv
`timescale 1ns / 1ps

// Counts the layers that hold any hit inside one window of time bins. A stored
// word is nonzero exactly when its valid bit is set, so the valid bits suffice.
module hwlc_win_count #(
    parameter int NUM_TIME_BINS = 16,
    parameter int NUM_LAYERS    = 6
) (
    input  logic [NUM_TIME_BINS*NUM_LAYERS-1:0] i_valid,
    input  logic [hwlc_pkg::TBIN_W-1:0]         i_start,
    input  logic [hwlc_pkg::CFG_W-1:0]          i_len,
    output logic [$clog2(NUM_LAYERS+1)-1:0]     o_count
);
    import hwlc_pkg::*;

    localparam int CW = $clog2(NUM_LAYERS + 1);

    logic [NUM_TIME_BINS-1:0] w_in_win;
    logic [CFG_W-1:0]         w_start;
    logic [CFG_W-1:0]         w_end;

    assign w_start = CFG_W'(i_start);
    assign w_end   = w_start + i_len;

    always_comb begin
        for (int t = 0; t < NUM_TIME_BINS; t++) begin
            w_in_win[t] = (CFG_W'(t) >= w_start) && (CFG_W'(t) < w_end);
        end
    end

    always_comb begin
        logic any_hit;
        o_count = '0;
        for (int l = 0; l < NUM_LAYERS; l++) begin
            any_hit = 1'b0;
            for (int t = 0; t < NUM_TIME_BINS; t++) begin
                any_hit = any_hit | (i_valid[t*NUM_LAYERS+l] & w_in_win[t]);
            end
            o_count = o_count + CW'(any_hit);
        end
    end

endmodule
